// File: rtl/skc_pkg.sv
// Package for the set-associative key cache: sizes, codes and control types.
package skc_pkg;

  localparam int ENTRY_BITS    = 13;
  localparam int WAY_BITS      = 4;
  localparam int PAYLOAD_WIDTH = 64;

  localparam int BUCKET_BITS = ENTRY_BITS - WAY_BITS;
  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int NUM_WAYS    = 1 << WAY_BITS;
  localparam int NUM_ENTRIES = 1 << ENTRY_BITS;

  localparam int KEY_W        = 32;
  localparam int PAYLOAD_W    = 64;
  localparam int STATUS_W     = 3;
  localparam int BUCKET_OUT_W = 9;
  localparam int WAY_OUT_W    = 4;

  localparam logic [KEY_W-1:0] HASH_MULT    = 32'h9E37_79B1;
  localparam logic [KEY_W-1:0] KEY_EMPTY    = 32'h0000_0000;
  localparam logic [KEY_W-1:0] KEY_RESERVED = 32'h0000_0001;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_FULL     = 3'd3,
    ST_RESERVED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clr_we;
    logic load_in;
    logic hash_en;
    logic tag_re;
    logic cmp_en;
    logic res_load;
  } skc_cmd_t;

  typedef struct packed {
    logic clr_last;
  } skc_sts_t;

endpackage

// File: rtl/skc_if.sv
// Request and response channel interfaces of the key cache.
interface skc_req_if import skc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload_in;

  modport source (output valid, command, key, payload_in, input ready);
  modport sink   (input valid, command, key, payload_in, output ready);
endinterface

interface skc_rsp_if import skc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [PAYLOAD_W-1:0]    payload_out;
  logic [BUCKET_OUT_W-1:0] bucket_num;
  logic [WAY_OUT_W-1:0]    way_index;

  modport source (output valid, status, payload_out, bucket_num, way_index, input ready);
  modport sink   (input valid, status, payload_out, bucket_num, way_index, output ready);
endinterface

// File: rtl/skc_ctrl.sv
// Controller state machine of the key cache: sequencing, handshakes, clear pass.
module skc_ctrl import skc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  skc_sts_t sts_i,
  output skc_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_HASH;
      S_HASH:  state_d = S_READ;
      S_READ:  state_d = S_CMP;
      S_CMP:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr_we = 1'b1;
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_HASH:  cmd_o.hash_en = 1'b1;
      S_READ:  cmd_o.tag_re  = 1'b1;
      S_CMP:   cmd_o.cmp_en  = 1'b1;
      S_DONE:  cmd_o.res_load = out_free;
      default: cmd_o = '0;
    endcase
    out_valid_d = cmd_o.res_load || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/skc_datapath.sv
// Datapath of the key cache: hash, tag and payload memories, way compare, result word.
module skc_datapath import skc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  skc_cmd_t                cmd_i,
  output skc_sts_t                sts_o,
  input  logic                    command_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic [PAYLOAD_W-1:0]    payload_in_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [PAYLOAD_W-1:0]    payload_out_o,
  output logic [BUCKET_OUT_W-1:0] bucket_num_o,
  output logic [WAY_OUT_W-1:0]    way_index_o
);

  typedef logic [NUM_WAYS-1:0][KEY_W-1:0] tag_row_t;

  tag_row_t                 tag_mem [NUM_BUCKETS];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [NUM_ENTRIES];

  logic [BUCKET_BITS-1:0]   clr_cnt_q;
  logic                     cmd_q;
  logic [KEY_W-1:0]         key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_in_q;
  logic [BUCKET_BITS-1:0]   bucket_q;
  tag_row_t                 tag_row_q;
  status_e                  res_status_q;
  logic [WAY_BITS-1:0]      res_way_q;
  logic [PAYLOAD_WIDTH-1:0] pay_rd_q;

  logic [STATUS_W-1:0]      out_status_q;
  logic [PAYLOAD_W-1:0]     out_pay_q;
  logic [BUCKET_OUT_W-1:0]  out_bucket_q;
  logic [WAY_OUT_W-1:0]     out_way_q;

  logic [KEY_W-1:0]         mixed;
  logic                     reserved;
  logic                     found;
  logic                     have_empty;
  logic [WAY_BITS-1:0]      hit_way;
  logic [WAY_BITS-1:0]      free_way;
  status_e                  status_d;
  logic [WAY_BITS-1:0]      way_d;
  logic                     do_write;
  logic                     do_read;
  tag_row_t                 new_row;
  logic                     tag_we;
  logic [BUCKET_BITS-1:0]   tag_wa;
  tag_row_t                 tag_wd;

  // clear pass over the tag rows after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clr_last = &clr_cnt_q;

  assign mixed = (key_q ^ (key_q >> 16)) * HASH_MULT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q    <= command_i;
      key_q    <= key_i;
      pay_in_q <= payload_in_i[PAYLOAD_WIDTH-1:0];
    end
    if (cmd_i.hash_en) begin
      bucket_q <= mixed[KEY_W-1 -: BUCKET_BITS];
    end
  end

  // way compare: lowest matching and lowest empty way
  always_comb begin
    found      = 1'b0;
    have_empty = 1'b0;
    hit_way    = '0;
    free_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (tag_row_q[w] == key_q) begin
        found   = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (tag_row_q[w] == KEY_EMPTY) begin
        have_empty = 1'b1;
        free_way   = WAY_BITS'(w);
      end
    end
  end

  assign reserved = (key_q == KEY_EMPTY) || (key_q == KEY_RESERVED);

  always_comb begin
    status_d = ST_OK;
    way_d    = '0;
    do_write = 1'b0;
    do_read  = 1'b0;
    priority if (reserved) begin
      status_d = ST_RESERVED;
    end else if (cmd_q == CMD_LOOKUP) begin
      if (found) begin
        way_d   = hit_way;
        do_read = 1'b1;
      end else begin
        status_d = ST_MISS;
      end
    end else if (found) begin
      status_d = ST_PRESENT;
    end else if (!have_empty) begin
      status_d = ST_FULL;
    end else begin
      way_d    = free_way;
      do_write = 1'b1;
    end
  end

  always_comb begin
    new_row           = tag_row_q;
    new_row[free_way] = key_q;
  end

  assign tag_we = cmd_i.clr_we || (cmd_i.cmp_en && do_write);
  assign tag_wa = cmd_i.clr_we ? clr_cnt_q : bucket_q;
  assign tag_wd = cmd_i.clr_we ? '0 : new_row;

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (cmd_i.tag_re) begin
      tag_row_q <= tag_mem[bucket_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en && do_write) begin
      pay_mem[{bucket_q, free_way}] <= pay_in_q;
    end
    if (cmd_i.cmp_en && do_read) begin
      pay_rd_q <= pay_mem[{bucket_q, hit_way}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      res_status_q <= status_d;
      res_way_q    <= way_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= res_status_q;
      out_bucket_q <= BUCKET_OUT_W'(bucket_q);
      out_way_q    <= WAY_OUT_W'(res_way_q);
      if (res_status_q == ST_OK && cmd_q == CMD_LOOKUP) begin
        out_pay_q <= PAYLOAD_W'(pay_rd_q);
      end else begin
        out_pay_q <= '0;
      end
    end
  end

  assign status_o      = out_status_q;
  assign payload_out_o = out_pay_q;
  assign bucket_num_o  = out_bucket_q;
  assign way_index_o   = out_way_q;

endmodule

// File: rtl/set_associative_key_cache.sv
// Top level of the set-associative key cache.
//
//   channel  dir  words
//   req_i    in   command, key, payload_in
//   rsp_o    out  status, payload_out, bucket_num, way_index
//
// Words pass one at a time: accept, hash multiply, tag row read, way compare with
// tag/payload write or payload read, result load. The tag row memory port and the
// payload memory port set this chain; no new word is taken before the last is loaded.
// After reset the tag memory is cleared, all 512 rows one row a cycle, req_i not ready.
// A result waits in the output register while the next word is taken; a new result
// is held back until rsp_o frees it.
module set_associative_key_cache import skc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  skc_req_if.sink    req_i,
  skc_rsp_if.source  rsp_o
);

  skc_cmd_t cmd;
  skc_sts_t sts;

  skc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  skc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .command_i      (req_i.command),
    .key_i          (req_i.key),
    .payload_in_i   (req_i.payload_in),
    .status_o       (rsp_o.status),
    .payload_out_o  (rsp_o.payload_out),
    .bucket_num_o   (rsp_o.bucket_num),
    .way_index_o    (rsp_o.way_index)
  );

endmodule

// File: rtl/skc_checker.sv
// Port-level checks of the key cache, bound to the top level.
module skc_checker import skc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [STATUS_W-1:0]     status_i,
  input logic [PAYLOAD_W-1:0]    payload_out_i,
  input logic [WAY_OUT_W-1:0]    way_index_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response word dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous word in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_RESERVED)
    else $error("undefined status code");

  a_reserved_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_RESERVED |-> way_index_i == '0 && payload_out_i == '0)
    else $error("reserved key gave way or payload");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_MISS |-> way_index_i == '0 && payload_out_i == '0)
    else $error("miss gave way or payload");

endmodule

bind set_associative_key_cache skc_checker u_skc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .payload_out_i (rsp_o.payload_out),
  .way_index_i   (rsp_o.way_index)
);

// File: test/set_associative_key_cache_tb.sv
// Self-checking testbench for the set-associative key cache: hashing, hits, fills and full buckets.
`timescale 1ns / 100ps

module set_associative_key_cache_tb;
  import skc_pkg::*;

  localparam int POOL_BUCKETS = 3;
  localparam int POOL_KEYS    = 24;

  typedef struct {
    status_e                 status;
    logic [PAYLOAD_W-1:0]    payload;
    logic [BUCKET_OUT_W-1:0] bucket;
    logic [WAY_OUT_W-1:0]    way;
  } cache_result_t;

  logic clk_i;
  logic rst_ni;

  skc_req_if req ();
  skc_rsp_if rsp ();

  set_associative_key_cache u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  logic [KEY_W-1:0]     shadow_tags     [NUM_ENTRIES];
  logic [PAYLOAD_W-1:0] shadow_payloads [NUM_ENTRIES];
  cache_result_t        pending_results [$];
  logic [KEY_W-1:0]     hot_keys        [POOL_BUCKETS][POOL_KEYS];
  logic [KEY_W-1:0]     seen_keys       [$];

  int err_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  function automatic logic [BUCKET_OUT_W-1:0] hash_bucket(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] mixed;
    mixed = (key ^ (key >> 16)) * HASH_MULT;
    return mixed[KEY_W-1 -: BUCKET_BITS];
  endfunction

  function automatic logic [KEY_W-1:0] find_bucket_key(logic [BUCKET_OUT_W-1:0] bucket);
    logic [KEY_W-1:0] key;
    key = $urandom;
    while (key <= KEY_RESERVED || hash_bucket(key) != bucket) key = $urandom;
    return key;
  endfunction

  function automatic cache_result_t predict_access(cmd_e cmd, logic [KEY_W-1:0] key,
                                                   logic [PAYLOAD_W-1:0] pay);
    cache_result_t res;
    int base;
    bit found;
    bit have_empty;
    int hit_way;
    int free_way;
    res.bucket  = hash_bucket(key);
    res.payload = '0;
    res.way     = '0;
    base        = int'(res.bucket) * NUM_WAYS;
    found       = 1'b0;
    have_empty  = 1'b0;
    hit_way     = 0;
    free_way    = 0;
    if (key == KEY_EMPTY || key == KEY_RESERVED) begin
      res.status = ST_RESERVED;
    end else begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!found && shadow_tags[base + w] == key) begin
          found   = 1'b1;
          hit_way = w;
        end
        if (!have_empty && shadow_tags[base + w] == KEY_EMPTY) begin
          have_empty = 1'b1;
          free_way   = w;
        end
      end
      if (cmd == CMD_LOOKUP) begin
        if (found) begin
          res.status  = ST_OK;
          res.payload = shadow_payloads[base + hit_way];
          res.way     = WAY_OUT_W'(hit_way);
        end else begin
          res.status = ST_MISS;
        end
      end else if (found) begin
        res.status = ST_PRESENT;
      end else if (!have_empty) begin
        res.status = ST_FULL;
      end else begin
        shadow_tags[base + free_way]     = key;
        shadow_payloads[base + free_way] = pay;
        res.status = ST_OK;
        res.way    = WAY_OUT_W'(free_way);
      end
    end
    return res;
  endfunction

  // Drive one request word and wait until it is taken.
  task automatic send_word(cmd_e cmd, logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] pay);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    pending_results.push_back(predict_access(cmd, key, pay));
    req.valid      <= 1'b1;
    req.command    <= cmd;
    req.key        <= key;
    req.payload_in <= pay;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic test_reserved_keys();
    send_word(CMD_LOOKUP, KEY_EMPTY, '0);
    send_word(CMD_INSERT, KEY_EMPTY, '1);
    send_word(CMD_LOOKUP, KEY_RESERVED, '0);
    send_word(CMD_INSERT, KEY_RESERVED, {$urandom, $urandom});
  endtask

  task automatic test_lookup_miss();
    send_word(CMD_LOOKUP, 32'h0000_0002, '1);
  endtask

  // Fill the bucket of the all-ones key, overflow it, then probe hits and a duplicate.
  task automatic test_full_bucket();
    logic [BUCKET_OUT_W-1:0] target;
    logic [KEY_W-1:0]        fill_keys [NUM_WAYS + 1];
    target       = hash_bucket('1);
    fill_keys[0] = '1;
    for (int i = 1; i <= NUM_WAYS; i++) fill_keys[i] = find_bucket_key(target);
    send_word(CMD_INSERT, fill_keys[0], '1);
    send_word(CMD_INSERT, fill_keys[1], '0);
    for (int i = 2; i <= NUM_WAYS; i++) send_word(CMD_INSERT, fill_keys[i], {$urandom, $urandom});
    send_word(CMD_LOOKUP, fill_keys[0], {$urandom, $urandom});
    send_word(CMD_INSERT, fill_keys[0], {$urandom, $urandom});
    send_word(CMD_LOOKUP, fill_keys[NUM_WAYS - 1], '0);
  endtask

  task automatic build_key_pools();
    logic [BUCKET_OUT_W-1:0] bucket;
    for (int b = 0; b < POOL_BUCKETS; b++) begin
      bucket = BUCKET_OUT_W'($urandom_range(NUM_BUCKETS - 1));
      for (int k = 0; k < POOL_KEYS; k++) hot_keys[b][k] = find_bucket_key(bucket);
    end
  endtask

  // Mostly keys crowding a few buckets, so hits, duplicates and overflow recur.
  task automatic test_random_traffic(int count);
    int pick;
    cmd_e cmd;
    logic [KEY_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      cmd  = cmd_e'($urandom_range(1));
      if (pick < 10) begin
        key = KEY_W'($urandom_range(1));
      end else if (pick < 30 || seen_keys.size() == 0) begin
        key = $urandom;
        seen_keys.push_back(key);
      end else if (pick < 45) begin
        key = seen_keys[$urandom_range(seen_keys.size() - 1)];
      end else begin
        key = hot_keys[$urandom_range(POOL_BUCKETS - 1)][$urandom_range(POOL_KEYS - 1)];
      end
      send_word(cmd, key, {$urandom, $urandom});
    end
  endtask

  always @(negedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cache_result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t unexpected word: expected none, actual status %0d", $time, rsp.status);
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status) begin
          err_count++;
          $display("%0t status: expected %0d, actual %0d", $time, want.status, rsp.status);
        end
        if (rsp.payload_out !== want.payload) begin
          err_count++;
          $display("%0t payload_out: expected %h, actual %h", $time, want.payload,
                   rsp.payload_out);
        end
        if (rsp.bucket_num !== want.bucket) begin
          err_count++;
          $display("%0t bucket_num: expected %0d, actual %0d", $time, want.bucket,
                   rsp.bucket_num);
        end
        if (rsp.way_index !== want.way) begin
          err_count++;
          $display("%0t way_index: expected %0d, actual %0d", $time, want.way, rsp.way_index);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_tags[i]     = KEY_EMPTY;
      shadow_payloads[i] = '0;
    end
    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.command    = CMD_LOOKUP;
    req.key        = '0;
    req.payload_in = '0;
    rsp.ready      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reserved_keys();
    test_lookup_miss();
    test_full_bucket();
    pause_until_drained();

    build_key_pools();
    test_random_traffic(125);
    pause_until_drained();
    send_idle_pct  = 63;
    test_random_traffic(125);
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    test_random_traffic(125);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    test_random_traffic(125);

    @(negedge clk_i);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
